### rtl/uart_8n1_transceiver_assert.svh
// Assertion macros shared by the UART transceiver RTL.
`ifndef UART_8N1_TRANSCEIVER_ASSERT_SVH
`define UART_8N1_TRANSCEIVER_ASSERT_SVH
`ifndef SYNTH
// Property must hold in the same cycle.
`define U8T_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("u8t assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define U8T_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("u8t assertion failed");
`else
`define U8T_ASSERT(label, clk, rst, prop)
`define U8T_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### rtl/u8t_pkg.sv
// Shared types and constants for the UART transceiver.
package u8t_pkg;

   localparam int unsigned FIFO_DEPTH_DEF = 256;
   localparam int unsigned TPB_W          = 16;
   localparam int unsigned RX_WAIT_W      = 17;
   localparam int unsigned RX_LEVEL_W     = 9;
   localparam int unsigned BIT_COUNT_W    = 4;

   localparam logic [TPB_W-1:0]       TPB_RESET   = 16'd5208;
   localparam logic [BIT_COUNT_W-1:0] DATA_BITS   = 4'd8;
   localparam logic [BIT_COUNT_W-1:0] STOP_COUNT  = 4'd9;
   localparam logic [BIT_COUNT_W-1:0] START_COUNT = 4'd0;

   // One input beat: one tick of the serial engines.
   typedef struct packed {
      logic       rx_line;
      logic       tx_write;
      logic [7:0] tx_byte;
      logic       rx_read;
   } item_type;

   typedef struct packed {
      logic                  rx_valid;
      logic [7:0]            rx_byte;
      logic [RX_LEVEL_W-1:0] rx_level;
      logic                  rx_dropped;
   } rx_status_type;

   typedef struct packed {
      logic tx_line;
      logic tx_accepted;
      logic tx_active;
   } tx_status_type;

endpackage

### rtl/u8t_req_if.sv
// Request channel: one tick of line sample, transmit write and receive pop.
interface u8t_req_if;
   logic       valid;
   logic       ready;
   logic       rx_line;
   logic       tx_write;
   logic [7:0] tx_byte;
   logic       rx_read;

   modport source (output valid, rx_line, tx_write, tx_byte, rx_read, input ready);
   modport sink   (input valid, rx_line, tx_write, tx_byte, rx_read, output ready);
endinterface

### rtl/u8t_rsp_if.sv
// Response channel: pin level, FIFO status and popped byte for one tick.
interface u8t_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_line;
   logic       tx_accepted;
   logic       rx_valid;
   logic [7:0] rx_byte;
   logic [8:0] rx_level;
   logic       tx_active;
   logic       rx_dropped;

   modport source (output valid, tx_line, tx_accepted, rx_valid, rx_byte, rx_level,
                   tx_active, rx_dropped, input ready);
   modport sink   (input valid, tx_line, tx_accepted, rx_valid, rx_byte, rx_level,
                   tx_active, rx_dropped, output ready);
endinterface

### rtl/uart_8n1_transceiver.sv
// Top level of the 8N1 UART transceiver with transmit and receive FIFOs.
//
// Usage:
//   req_ch carries one beat per serial tick: the sampled rx pin, an optional
//   byte to queue for transmit and an optional pop of a received byte.
//   rsp_ch returns one beat per request beat, in order: the tx pin level,
//   whether the byte was queued, the popped byte, the receive FIFO level,
//   transmitter busy and a receive overflow flag.
//   csr_write_en / csr_write_data load ticks_per_bit (reset 5208); write it
//   only while no beat is in flight. New values apply to bit waits that
//   start afterwards.
// Timing:
//   A beat waits in the input register, is processed in one pass and shows
//   on rsp_ch the next cycle; a stalled rsp_ch can hold it in the register.
//   One beat per cycle while rsp_ch is not stalled; the path is the engine
//   update plus one FIFO access per side (one write port, one registered read each).
// Reset and stalls:
//   Reset empties both FIFOs through their pointers and idles both lines
//   high; there is no clearing pass, so beats are taken right after reset.
//   When rsp_ch is stalled the held response blocks the pipeline and
//   req_ch.ready drops once the input register is full.
`include "uart_8n1_transceiver_assert.svh"
module uart_8n1_transceiver
   import u8t_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   u8t_req_if.sink          req_ch,
   u8t_rsp_if.source        rsp_ch,
   input  logic             csr_write_en,
   input  logic [TPB_W-1:0] csr_write_data
);

   logic             in_valid_ff;
   item_type         in_item_ff;
   logic             out_valid_ff;
   logic [TPB_W-1:0] tpb_ff;
   logic             step;

   rx_status_type rx_st;
   tx_status_type tx_st;

   // process the held beat when the response slot is free or draining
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tpb_ff       <= TPB_RESET;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            tpb_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.rx_line  <= req_ch.rx_line;
         in_item_ff.tx_write <= req_ch.tx_write;
         in_item_ff.tx_byte  <= req_ch.tx_byte;
         in_item_ff.rx_read  <= req_ch.rx_read;
      end
   end

   u8t_rx #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_rx (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_item_ff),
      .ticks_per_bit (tpb_ff),
      .status        (rx_st)
   );

   u8t_tx #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_tx (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_item_ff),
      .ticks_per_bit (tpb_ff),
      .status        (tx_st)
   );

   // engine state registers double as the response register
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.tx_line     = tx_st.tx_line;
   assign rsp_ch.tx_accepted = tx_st.tx_accepted;
   assign rsp_ch.rx_valid    = rx_st.rx_valid;
   assign rsp_ch.rx_byte     = rx_st.rx_byte;
   assign rsp_ch.rx_level    = rx_st.rx_level;
   assign rsp_ch.tx_active   = tx_st.tx_active;
   assign rsp_ch.rx_dropped  = rx_st.rx_dropped;

   `U8T_ASSERT(a_stall_backs_up, clock, reset, !(in_valid_ff && out_valid_ff && !rsp_ch.ready) || !req_ch.ready)
   `U8T_ASSERT_NEXT(a_accept_needs_write, clock, reset, step && !in_item_ff.tx_write, !tx_st.tx_accepted)
   `U8T_ASSERT_NEXT(a_pop_needs_read, clock, reset, step && !in_item_ff.rx_read, !rx_st.rx_valid)

endmodule

### rtl/u8t_rx.sv
// Receive engine with its FIFO.
`include "uart_8n1_transceiver_assert.svh"
module u8t_rx
   import u8t_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  item_type         item,
   input  logic [TPB_W-1:0] ticks_per_bit,
   output rx_status_type    status
);

   localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned LW = (FW > RX_LEVEL_W) ? FW : RX_LEVEL_W;
   localparam logic [FW-1:0] FULL    = FW'(FIFO_DEPTH);
   localparam logic [PW-1:0] LAST_PT = PW'(FIFO_DEPTH - 1);

   logic                   recv_ff,   recv_in;
   logic [BIT_COUNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [RX_WAIT_W-1:0]   wait_ff,   wait_in;
   logic [7:0]             shift_ff,  shift_in;
   logic                   prev_ff;
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]          fill_ff,   fill_in;
   logic                   valid_ff, dropped_ff, bypass_ff;
   logic [7:0]             bypass_byte_ff, mem_rd_ff;
   logic [7:0]             rx_mem [FIFO_DEPTH];

   logic          store, push, pop, bypass, dropped, fall_seen;
   logic [FW-1:0] fill_mid;
   logic [LW-1:0] level_wide;

   // falling edge on an idle line
   assign fall_seen = !recv_ff && prev_ff && !item.rx_line;

   always_comb begin
      recv_in   = recv_ff;
      bitcnt_in = bitcnt_ff;
      wait_in   = wait_ff;
      shift_in  = shift_ff;
      store     = 1'b0;
      if (recv_ff) begin
         if (wait_ff > RX_WAIT_W'(1)) begin
            wait_in = wait_ff - RX_WAIT_W'(1);
         end else if (bitcnt_ff < DATA_BITS) begin
            shift_in[bitcnt_ff[2:0]] = item.rx_line;
            bitcnt_in = bitcnt_ff + BIT_COUNT_W'(1);
            wait_in   = RX_WAIT_W'(ticks_per_bit);
         end else begin
            // mid stop bit: frame done, level not checked
            store   = 1'b1;
            recv_in = 1'b0;
         end
      end else if (fall_seen) begin
         recv_in   = 1'b1;
         bitcnt_in = START_COUNT;
         shift_in  = 8'h00;
         // 1.5 bit times to the middle of data bit 0
         wait_in   = RX_WAIT_W'(ticks_per_bit) + RX_WAIT_W'(ticks_per_bit[TPB_W-1:1]);
      end
   end

   always_comb begin
      push      = store && (fill_ff != FULL);
      dropped   = store && (fill_ff == FULL);
      fill_mid  = fill_ff + FW'(push);
      pop       = item.rx_read && (fill_mid != '0);
      bypass    = pop && (fill_ff == '0);
      fill_in   = fill_mid - FW'(pop);
      wr_ptr_in = push ? ((wr_ptr_ff == LAST_PT) ? '0 : wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? ((rd_ptr_ff == LAST_PT) ? '0 : rd_ptr_ff + PW'(1)) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff    <= 1'b0;
         bitcnt_ff  <= '0;
         wait_ff    <= '0;
         shift_ff   <= '0;
         prev_ff    <= 1'b1;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         valid_ff   <= 1'b0;
         dropped_ff <= 1'b0;
         bypass_ff  <= 1'b0;
      end else if (step) begin
         recv_ff    <= recv_in;
         bitcnt_ff  <= bitcnt_in;
         wait_ff    <= wait_in;
         shift_ff   <= shift_in;
         prev_ff    <= item.rx_line;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
         valid_ff   <= pop;
         dropped_ff <= dropped;
         bypass_ff  <= bypass;
      end
   end

   // byte stored and popped in the same tick skips the array
   always_ff @(posedge clock) begin
      if (step) begin
         bypass_byte_ff <= shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step && push) begin
         rx_mem[wr_ptr_ff] <= shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step && pop) begin
         mem_rd_ff <= rx_mem[rd_ptr_ff];
      end
   end

   assign level_wide        = LW'(fill_ff);
   assign status.rx_valid   = valid_ff;
   assign status.rx_byte    = !valid_ff ? 8'h00 : (bypass_ff ? bypass_byte_ff : mem_rd_ff);
   assign status.rx_level   = level_wide[RX_LEVEL_W-1:0];
   assign status.rx_dropped = dropped_ff;

   `U8T_ASSERT_NEXT(a_drop_when_full, clock, reset, step && store && fill_ff == FULL, dropped_ff)
   `U8T_ASSERT(a_bypass_is_pop, clock, reset, !bypass_ff || valid_ff)
   `U8T_ASSERT_NEXT(a_start_fall, clock, reset, step && fall_seen, recv_ff && bitcnt_ff == START_COUNT)

endmodule

### rtl/u8t_tx.sv
// Transmit engine with its FIFO.
module u8t_tx
   import u8t_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  item_type         item,
   input  logic [TPB_W-1:0] ticks_per_bit,
   output tx_status_type    status
);

   localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
   localparam logic [FW-1:0] FULL    = FW'(FIFO_DEPTH);
   localparam logic [PW-1:0] LAST_PT = PW'(FIFO_DEPTH - 1);

   logic                   sending_ff, sending_in;
   logic [BIT_COUNT_W-1:0] bitcnt_ff,  bitcnt_in;
   logic [TPB_W-1:0]       wait_ff,    wait_in;
   logic                   level_ff,   level_in;
   logic [PW-1:0]          wr_ptr_ff,  wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff,  rd_ptr_in;
   logic [FW-1:0]          fill_ff,    fill_in;
   logic                   accepted_ff;
   logic [7:0]             data_ff;
   logic [7:0]             tx_mem [FIFO_DEPTH];

   logic          fire, push;
   logic [FW-1:0] fill_mid;
   logic [2:0]    data_idx;

   assign data_idx = 3'(bitcnt_ff - BIT_COUNT_W'(1));

   always_comb begin
      sending_in = sending_ff;
      bitcnt_in  = bitcnt_ff;
      wait_in    = wait_ff;
      level_in   = level_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_mid   = fill_ff;
      fire       = sending_ff && (wait_ff <= TPB_W'(1));
      if (sending_ff && !fire) begin
         wait_in = wait_ff - TPB_W'(1);
      end
      if (fire) begin
         if (bitcnt_ff == START_COUNT) begin
            level_in = 1'b0;
         end else if (bitcnt_ff <= DATA_BITS) begin
            level_in = data_ff[data_idx];
         end else begin
            level_in = 1'b1;
         end
         bitcnt_in = bitcnt_ff + BIT_COUNT_W'(1);
         wait_in   = ticks_per_bit;
         if (bitcnt_ff >= STOP_COUNT) begin
            // stop bit out: retire the byte
            rd_ptr_in = (rd_ptr_ff == LAST_PT) ? '0 : rd_ptr_ff + PW'(1);
            if (fill_ff != '0) begin
               fill_mid = fill_ff - FW'(1);
            end
            bitcnt_in = START_COUNT;
            if (fill_mid == '0) begin
               sending_in = 1'b0;
            end
         end
      end
      push      = item.tx_write && (fill_mid != FULL);
      fill_in   = fill_mid + FW'(push);
      wr_ptr_in = push ? ((wr_ptr_ff == LAST_PT) ? '0 : wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      if (!sending_in && fill_in != '0) begin
         sending_in = 1'b1;
         bitcnt_in  = START_COUNT;
         wait_in    = ticks_per_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff  <= 1'b0;
         bitcnt_ff   <= '0;
         wait_ff     <= '0;
         level_ff    <= 1'b1;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
         accepted_ff <= 1'b0;
      end else if (step) begin
         sending_ff  <= sending_in;
         bitcnt_ff   <= bitcnt_in;
         wait_ff     <= wait_in;
         level_ff    <= level_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
         accepted_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (step && push) begin
         tx_mem[wr_ptr_ff] <= item.tx_byte;
      end
   end

   // head byte, read every cycle; settled well before its first data bit
   always_ff @(posedge clock) begin
      data_ff <= tx_mem[rd_ptr_ff];
   end

   assign status.tx_line     = level_ff;
   assign status.tx_accepted = accepted_ff;
   assign status.tx_active   = sending_ff;

endmodule

### bench/tb_top.sv
// Self-checking bench for the 8N1 UART transceiver: serial stimulus, status prediction, checks.
`timescale 1ns / 1ps
module tb_top;
   import u8t_pkg::*;

   localparam int CYCLE_LIMIT    = 100_000;
   localparam int TX_FILL_TICKS  = 280;
   localparam int RX_FILL_FRAMES = 24;
   localparam int PHASE_BEATS    = 70;

   // Expected response beat, built from the package status types.
   typedef struct packed {
      tx_status_type tx;
      rx_status_type rx;
   } tick_status_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [TPB_W-1:0] csr_write_data;

   u8t_req_if req_bus ();
   u8t_rsp_if rsp_bus ();

   uart_8n1_transceiver dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5ns clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow copy of the UART: divisor, both FIFOs and both engines.
   // Pointers are 8 bits, so they wrap at the 256-entry depth.
   // ---------------------------------------------------------------
   logic [TPB_W-1:0]      baud_div = TPB_RESET;

   logic [7:0]            rx_mem [FIFO_DEPTH_DEF];
   logic [7:0]            rx_wr = '0;
   logic [7:0]            rx_rd = '0;
   logic [RX_LEVEL_W-1:0] rx_count = '0;
   logic                  rx_busy = 1'b0;
   logic [BIT_COUNT_W-1:0] rx_bits = '0;
   logic [RX_WAIT_W-1:0]  rx_wait_cnt = '0;
   logic [7:0]            rx_sr = '0;
   logic                  rx_last = 1'b1;

   logic [7:0]            tx_mem [FIFO_DEPTH_DEF];
   logic [7:0]            tx_wr = '0;
   logic [7:0]            tx_rd = '0;
   logic [RX_LEVEL_W-1:0] tx_count = '0;
   logic                  tx_busy = 1'b0;
   logic [BIT_COUNT_W-1:0] tx_bits = '0;
   logic [TPB_W-1:0]      tx_wait_cnt = '0;
   logic                  tx_pin = 1'b1;

   tick_status_type pending_status [$];

   // Bench controls.
   bit          quiet = 1'b0;       // no idling on either side
   bit          long_hold = 1'b0;   // response side held off
   int unsigned write_pct = 0;      // chance of a tx write per beat
   int unsigned pop_pct = 0;        // chance of an rx pop per beat
   int          stall_left = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          beats_sent = 0;

   // One serial tick. Order: rx engine, pop, tx engine, queue, tx start.
   function automatic tick_status_type step_uart(input item_type beat);
      tick_status_type st;
      logic [RX_WAIT_W:0] span;
      st = '0;

      // Receive engine. Edges are ignored while a frame is in progress.
      if (rx_busy) begin
         if (rx_wait_cnt > 1) begin
            rx_wait_cnt = rx_wait_cnt - 1'b1;
         end else if (rx_bits < DATA_BITS) begin
            rx_sr[rx_bits[2:0]] = beat.rx_line;
            rx_bits = rx_bits + 1'b1;
            rx_wait_cnt = {1'b0, baud_div};
         end else begin
            // Mid stop bit: no stop check, drop when full.
            if (rx_count >= RX_LEVEL_W'(FIFO_DEPTH_DEF)) begin
               st.rx.rx_dropped = 1'b1;
            end else begin
               rx_mem[rx_wr] = rx_sr;
               rx_wr = rx_wr + 8'd1;
               rx_count = rx_count + 1'b1;
            end
            rx_busy = 1'b0;
         end
      end else if (rx_last && !beat.rx_line) begin
         rx_busy = 1'b1;
         rx_bits = START_COUNT;
         rx_sr = '0;
         span = (RX_WAIT_W + 1)'(baud_div) * (RX_WAIT_W + 1)'(3);
         rx_wait_cnt = span[RX_WAIT_W:1];
      end
      rx_last = beat.rx_line;

      // Pop; a byte stored above can leave in the same tick.
      if (beat.rx_read && rx_count != 0) begin
         st.rx.rx_valid = 1'b1;
         st.rx.rx_byte = rx_mem[rx_rd];
         rx_rd = rx_rd + 8'd1;
         rx_count = rx_count - 1'b1;
      end

      // Transmit engine: start, 8 data LSB first, stop.
      if (tx_busy) begin
         if (tx_wait_cnt > 1) begin
            tx_wait_cnt = tx_wait_cnt - 1'b1;
         end else begin
            if (tx_bits == START_COUNT)
               tx_pin = 1'b0;
            else if (tx_bits <= DATA_BITS)
               tx_pin = tx_mem[tx_rd][tx_bits - 1'b1];
            else
               tx_pin = 1'b1;
            tx_bits = tx_bits + 1'b1;
            tx_wait_cnt = baud_div;
            if (tx_bits > STOP_COUNT) begin
               tx_rd = tx_rd + 8'd1;
               if (tx_count != 0)
                  tx_count = tx_count - 1'b1;
               tx_bits = START_COUNT;
               if (tx_count == 0)
                  tx_busy = 1'b0;
            end
         end
      end

      if (beat.tx_write && tx_count < RX_LEVEL_W'(FIFO_DEPTH_DEF)) begin
         tx_mem[tx_wr] = beat.tx_byte;
         tx_wr = tx_wr + 8'd1;
         tx_count = tx_count + 1'b1;
         st.tx.tx_accepted = 1'b1;
      end

      // Start includes the one-bit wait before the start bit.
      if (!tx_busy && tx_count != 0) begin
         tx_busy = 1'b1;
         tx_bits = START_COUNT;
         tx_wait_cnt = baud_div;
      end

      st.tx.tx_line = tx_pin;
      st.tx.tx_active = tx_busy;
      st.rx.rx_level = rx_count;
      return st;
   endfunction

   // ---------------------------------------------------------------
   // Response side: check each accepted beat, random stalls.
   // ---------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [8:0] want,
                                         input logic [8:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_status();
      tick_status_type want;
      if (pending_status.size() == 0) begin
         $error("response beat with no tick outstanding");
         mismatch_count++;
         return;
      end
      want = pending_status.pop_front();
      compare_field("tx_line", 9'(want.tx.tx_line), 9'(rsp_bus.tx_line));
      compare_field("tx_accepted", 9'(want.tx.tx_accepted), 9'(rsp_bus.tx_accepted));
      compare_field("rx_valid", 9'(want.rx.rx_valid), 9'(rsp_bus.rx_valid));
      compare_field("rx_byte", 9'(want.rx.rx_byte), 9'(rsp_bus.rx_byte));
      compare_field("rx_level", want.rx.rx_level, rsp_bus.rx_level);
      compare_field("tx_active", 9'(want.tx.tx_active), 9'(rsp_bus.tx_active));
      compare_field("rx_dropped", 9'(want.rx.rx_dropped), 9'(rsp_bus.rx_dropped));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_status();
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);   // start a stall burst of random length
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Request side helpers.
   // ---------------------------------------------------------------
   // Offer one beat; valid stays high on return so back-to-back beats
   // never drop it within a step. The shadow model steps on accept.
   task automatic send_beat(input item_type beat);
      int gap;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 8);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.rx_line  <= beat.rx_line;
      req_bus.tx_write <= beat.tx_write;
      req_bus.tx_byte  <= beat.tx_byte;
      req_bus.rx_read  <= beat.rx_read;
      do @(posedge clock); while (!req_bus.ready);
      pending_status.push_back(step_uart(beat));
      beats_sent++;
   endtask

   // Beat with a given line level; tx write and rx pop at the current odds.
   task automatic line_tick(input logic level, input bit force_pop);
      item_type beat;
      beat.rx_line  = level;
      beat.tx_byte  = 8'($urandom);
      beat.tx_write = ($urandom_range(0, 99) < write_pct);
      beat.rx_read  = force_pop || ($urandom_range(0, 99) < pop_pct);
      send_beat(beat);
   endtask

   task automatic idle_ticks(input int count);
      for (int n = 0; n < count; n++)
         line_tick(1'b1, 1'b0);
   endtask

   // Divisors 0 and 1 both behave as one tick per bit.
   function automatic int bit_ticks();
      return (baud_div < 2) ? 1 : int'(baud_div);
   endfunction

   // One serial frame on rx_line at the current divisor. The sample
   // points fall mid-bit; pop_on_store raises rx_read on the tick the
   // byte lands in the FIFO.
   task automatic send_frame(input logic [7:0] data, input logic stop_level,
                             input bit pop_on_store);
      int   eff;
      int   store_at;
      logic level;
      eff = bit_ticks();
      store_at = (3 * eff) / 2 + 8 * eff;
      for (int n = 0; n < 10 * eff; n++) begin
         if (n < eff)
            level = 1'b0;
         else if (n < 9 * eff)
            level = data[(n - eff) / eff];
         else
            level = stop_level;
         line_tick(level, pop_on_store && n == store_at);
      end
   endtask

   // Pipeline drained: every beat sent has been answered.
   task automatic wait_all_status();
      req_bus.valid <= 1'b0;
      while (pending_status.size() != 0)
         @(posedge clock);
   endtask

   // Divisor write; only called with the pipeline drained.
   task automatic set_baud_div(input logic [TPB_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      baud_div = value;
   endtask

   // ---------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------
   // Reset divisor, idle line: pins high, pops on an empty FIFO.
   task automatic test_reset_state();
      write_pct = 0;
      pop_pct = 100;
      idle_ticks(6);
   endtask

   // Directed frames at one tick per bit: all-zero and all-one data,
   // toggling data with edges inside the frame, pop on empty, and a
   // pop in the very tick a byte is stored.
   task automatic test_small_divisor();
      item_type beat;
      wait_all_status();
      set_baud_div(16'd0);
      write_pct = 0;
      pop_pct = 0;
      beat = '{rx_line: 1'b1, tx_write: 1'b1, tx_byte: 8'hFF, rx_read: 1'b0};
      send_beat(beat);
      send_frame(8'h00, 1'b1, 1'b0);
      wait_all_status();
      set_baud_div(16'd1);
      beat.tx_byte = 8'h00;
      send_beat(beat);
      beat = '{rx_line: 1'b1, tx_write: 1'b0, tx_byte: 8'h00, rx_read: 1'b1};
      send_beat(beat);                   // pops 0x00
      send_beat(beat);                   // empty
      send_frame(8'hA5, 1'b1, 1'b1);
      send_frame(8'hFF, 1'b1, 1'b0);
      send_beat(beat);
      send_beat(beat);
   endtask

   // Tx FIFO written every tick, much faster than it drains at four
   // ticks per bit, so it fills and later writes are refused. The rx
   // line toggles at random; edges inside a frame must be ignored.
   task automatic test_tx_fill();
      wait_all_status();
      set_baud_div(16'd4);
      write_pct = 100;
      pop_pct = 1;
      for (int n = 0; n < TX_FILL_TICKS; n++)
         line_tick(1'($urandom_range(0, 1)), 1'b0);
      // let any frame in progress finish before the divisor changes
      write_pct = 0;
      idle_ticks(11 * bit_ticks());
   endtask

   // Back-to-back frames at one tick per bit with no pops: the rx level
   // climbs a byte per frame, then every byte is popped in order.
   task automatic test_rx_fill();
      wait_all_status();
      set_baud_div(16'd0);
      write_pct = 0;
      pop_pct = 0;
      for (int n = 0; n < RX_FILL_FRAMES; n++)
         send_frame(8'($urandom), 1'b1, 1'b0);
      for (int n = 0; n < RX_FILL_FRAMES + 4; n++)
         line_tick(1'b1, 1'b1);
   endtask

   // Response side held off for a long stretch while frames keep coming,
   // so the block fills and drops req ready; then the sender pauses
   // until every beat has been answered.
   task automatic test_backpressure();
      write_pct = 25;
      pop_pct = 10;
      fork
         begin
            long_hold <= 1'b1;
            repeat (150) @(posedge clock);
            long_hold <= 1'b0;
         end
         for (int n = 0; n < 8; n++)
            send_frame(8'($urandom), 1'b1, 1'b0);
      join
      wait_all_status();
      idle_ticks(20);
   endtask

   // Random traffic over several divisors: mostly clean frames, plus
   // glitches, cut-short frames, low stop bits and line noise. The last
   // phase runs without idling.
   task automatic test_random_traffic();
      logic [TPB_W-1:0] div_list [5];
      int start;
      int pick;
      int eff;
      div_list = '{16'd5, 16'd4, 16'($urandom_range(6, 12)), 16'd7, 16'd4};
      for (int phase = 0; phase < 5; phase++) begin
         wait_all_status();
         set_baud_div(div_list[phase]);
         if (phase == 4)
            quiet <= 1'b1;
         write_pct = $urandom_range(0, 15);
         pop_pct = $urandom_range(0, 8);
         eff = bit_ticks();
         start = beats_sent;
         while (beats_sent - start < PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_frame(8'($urandom), 1'b1, $urandom_range(0, 9) == 0);
               idle_ticks($urandom_range(0, 2 * eff));
            end else if (pick < 78) begin
               // glitch: short low pulse still starts a frame
               repeat ($urandom_range(1, eff)) line_tick(1'b0, 1'b0);
               idle_ticks($urandom_range(1, 12 * eff));
            end else if (pick < 86) begin
               // frame cut short
               repeat ($urandom_range(1, 6 * eff)) line_tick(1'b0, 1'b0);
               idle_ticks($urandom_range(1, 4 * eff));
            end else if (pick < 93) begin
               send_frame(8'($urandom), 1'b0, 1'b0);
               idle_ticks($urandom_range(1, 3 * eff));
            end else begin
               repeat ($urandom_range(4, 30))
                  line_tick(1'($urandom_range(0, 1)), 1'b0);
            end
         end
         // let any frame in progress finish before the divisor changes
         idle_ticks(11 * eff);
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence.
   // ---------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_write_data   = TPB_RESET;
      req_bus.valid    = 1'b0;
      req_bus.rx_line  = 1'b1;
      req_bus.tx_write = 1'b0;
      req_bus.tx_byte  = '0;
      req_bus.rx_read  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_small_divisor();
      test_tx_fill();
      test_rx_fill();
      test_backpressure();
      test_random_traffic();

      // wait for the last beat to be answered, then idle before the summary
      wait_all_status();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
